### rtl/rtcc_pkg.sv
// Shared types, register map codes and constants for the real-time counter block.
// Used by the channel interfaces, the register core and the top level.
// No dependencies.
`default_nettype none

package rtcc_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_COMPARE_DEF  = 4;
    localparam int COUNTER_BITS_DEF = 24;
    localparam int MAX_COMPARE      = 4;

    // Field widths.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 5;
    localparam int DATA_W   = 32;
    localparam int PRESC_W  = 12;

    // Prescaler range, trigger-overflow back-off and compare event bit base.
    localparam logic [DATA_W-1:0] PRESCALE_MAX    = 32'd4095;
    localparam int                TRIGOVF_BACKOFF = 15;
    localparam int                CMP_BIT_BASE    = 16;
    localparam int                NUM_EVENTS      = 6;
    localparam int                NUM_TASKS       = 4;

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

    // Register map.
    localparam logic [INDEX_W-1:0] REG_START     = 5'd0;
    localparam logic [INDEX_W-1:0] REG_STOP      = 5'd1;
    localparam logic [INDEX_W-1:0] REG_CLEAR     = 5'd2;
    localparam logic [INDEX_W-1:0] REG_TRIGOVF   = 5'd3;
    localparam logic [INDEX_W-1:0] REG_EVTICK    = 5'd4;
    localparam logic [INDEX_W-1:0] REG_EVOVF     = 5'd5;
    localparam logic [INDEX_W-1:0] REG_EVCMP3    = 5'd9;
    localparam logic [INDEX_W-1:0] REG_EVTEN     = 5'd10;
    localparam logic [INDEX_W-1:0] REG_EVTENSET  = 5'd11;
    localparam logic [INDEX_W-1:0] REG_EVTENCLR  = 5'd12;
    localparam logic [INDEX_W-1:0] REG_INTENSET  = 5'd13;
    localparam logic [INDEX_W-1:0] REG_INTENCLR  = 5'd14;
    localparam logic [INDEX_W-1:0] REG_COUNTER   = 5'd15;
    localparam logic [INDEX_W-1:0] REG_PRESCALER = 5'd16;
    localparam logic [INDEX_W-1:0] REG_CC0       = 5'd17;
    localparam logic [INDEX_W-1:0] REG_CC3       = 5'd20;

    // Task word slots.
    localparam int TASK_START = 0;
    localparam int TASK_STOP  = 1;
    localparam int TASK_CLEAR = 2;
    localparam int TASK_TRIG  = 3;

    // Event word slots and enable bits.
    localparam int EVT_TICK = 0;
    localparam int EVT_OVF  = 1;
    localparam int EVT_CMP0 = 2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  reg_index;
        logic [DATA_W-1:0]   write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pulse;
        logic              notify_pulse;
        logic              prescaler_error;
    } result_t;

endpackage

`default_nettype wire

### rtl/rtcc_if.sv
// Valid/ready channel interfaces for the command and response sides.
// Depends on rtcc_pkg for field widths.
`default_nettype none

interface rtcc_cmd_if import rtcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  reg_index;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output action, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input action, input reg_index, input write_data,
                    output ready);
endinterface

interface rtcc_rsp_if import rtcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_pulse;
    logic              notify_pulse;
    logic              prescaler_error;

    modport source (output valid, output read_data, output irq_pulse,
                    output notify_pulse, output prescaler_error, input ready);
    modport sink   (input valid, input read_data, input irq_pulse,
                    input notify_pulse, input prescaler_error, output ready);
endinterface

`default_nettype wire

### rtl/rtcc_core.sv
// Register file, prescaler and counter step logic of the real-time counter.
// State advances by one item whenever adv is high; the result is combinational.
// Depends on rtcc_pkg.
`default_nettype none

module rtcc_core import rtcc_pkg::*; #(
    parameter int NUM_COMPARE  = NUM_COMPARE_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire item_t   item,
    output result_t      res
);

    localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;
    localparam logic [COUNTER_BITS-1:0] CTR_TRIG = CTR_MAX - COUNTER_BITS'(TRIGOVF_BACKOFF);

    logic [COUNTER_BITS-1:0] count_reg, count_next;
    logic [PRESC_W-1:0]      presc_cnt_reg, presc_cnt_next;
    logic [PRESC_W-1:0]      presc_set_reg, presc_set_next;
    logic [DATA_W-1:0]       cc_reg     [MAX_COMPARE];
    logic [DATA_W-1:0]       cc_next    [MAX_COMPARE];
    logic [DATA_W-1:0]       evten_reg, evten_next;
    logic [DATA_W-1:0]       inten_reg, inten_next;
    logic [DATA_W-1:0]       event_reg  [NUM_EVENTS];
    logic [DATA_W-1:0]       event_next [NUM_EVENTS];
    logic [DATA_W-1:0]       task_reg   [NUM_TASKS];
    logic [DATA_W-1:0]       task_next  [NUM_TASKS];
    logic [DATA_W-1:0]       setclr_reg [2];
    logic [DATA_W-1:0]       setclr_next[2];
    logic                    ovf_pend_reg, ovf_pend_next;
    logic                    skip_reg, skip_next;
    logic                    clr_pend_reg, clr_pend_next;

    logic                    running;
    logic                    step_fire;
    logic                    is_write;
    logic [DATA_W-1:0]       count_ext;
    logic [2:0]              ev_sel;
    logic [1:0]              cc_sel;
    logic [1:0]              task_sel;
    logic                    fire;

    assign is_write  = (item.action == ACT_WRITE);
    assign running   = (task_reg[TASK_STOP] == '0) || (task_reg[TASK_START] != '0);
    assign step_fire = (item.action == ACT_TICK) && running && (presc_cnt_reg >= presc_set_reg);
    assign count_ext = DATA_W'(count_reg);
    assign ev_sel    = 3'(item.reg_index - REG_EVTICK);
    assign cc_sel    = 2'(item.reg_index - REG_CC0);
    assign task_sel  = item.reg_index[1:0];

    // Next state and result for the item held in the input register.
    always_comb
    begin
        count_next     = count_reg;
        presc_cnt_next = presc_cnt_reg;
        presc_set_next = presc_set_reg;
        cc_next        = cc_reg;
        evten_next     = evten_reg;
        inten_next     = inten_reg;
        event_next     = event_reg;
        task_next      = task_reg;
        setclr_next    = setclr_reg;
        ovf_pend_next  = ovf_pend_reg;
        skip_next      = skip_reg;
        clr_pend_next  = clr_pend_reg;
        fire           = 1'b0;
        res            = '0;

        // Register write decode.
        if (is_write)
        begin
            unique case (item.reg_index) inside
                REG_START:
                begin
                    task_next[TASK_START] = item.write_data;
                    if (item.write_data != '0)
                    begin
                        task_next[TASK_STOP] = '0;
                    end
                end
                REG_STOP:
                begin
                    task_next[TASK_STOP] = item.write_data;
                    if (item.write_data != '0)
                    begin
                        task_next[TASK_START] = '0;
                    end
                end
                REG_CLEAR:
                begin
                    task_next[TASK_CLEAR] = item.write_data;
                    clr_pend_next         = 1'b1;
                end
                REG_TRIGOVF:
                begin
                    task_next[TASK_TRIG] = item.write_data;
                    count_next           = CTR_TRIG;
                end
                [REG_EVTICK:REG_EVCMP3]:
                begin
                    event_next[ev_sel] = item.write_data;
                    res.notify_pulse   = 1'b1;
                end
                REG_EVTEN:
                begin
                    evten_next = item.write_data;
                end
                REG_EVTENSET:
                begin
                    setclr_next[0] = item.write_data;
                    evten_next     = evten_reg | item.write_data;
                end
                REG_EVTENCLR:
                begin
                    setclr_next[1] = item.write_data;
                    evten_next     = evten_reg & ~item.write_data;
                end
                REG_INTENSET:
                begin
                    inten_next = inten_reg | item.write_data;
                end
                REG_INTENCLR:
                begin
                    inten_next = inten_reg & ~item.write_data;
                end
                REG_PRESCALER:
                begin
                    if (item.write_data > PRESCALE_MAX)
                    begin
                        res.prescaler_error = 1'b1;
                    end
                    else
                    begin
                        presc_set_next = item.write_data[PRESC_W-1:0];
                    end
                end
                [REG_CC0:REG_CC3]:
                begin
                    cc_next[cc_sel] = item.write_data;
                end
                default:
                begin
                end
            endcase
        end

        // Register read mux.
        if (item.action == ACT_READ)
        begin
            unique case (item.reg_index) inside
                [REG_START:REG_TRIGOVF]:     res.read_data = task_reg[task_sel];
                [REG_EVTICK:REG_EVCMP3]:     res.read_data = event_reg[ev_sel];
                REG_EVTEN:                   res.read_data = evten_reg;
                [REG_EVTENSET:REG_EVTENCLR]: res.read_data = setclr_reg[item.reg_index[0] ? 0 : 1];
                [REG_INTENSET:REG_INTENCLR]: res.read_data = inten_reg;
                REG_COUNTER:                 res.read_data = count_ext;
                REG_PRESCALER:               res.read_data = DATA_W'(presc_set_reg);
                [REG_CC0:REG_CC3]:           res.read_data = cc_reg[cc_sel];
                default:                     res.read_data = '0;
            endcase
        end

        // Prescaler on a tick while running.
        if ((item.action == ACT_TICK) && running && !step_fire)
        begin
            presc_cnt_next = presc_cnt_reg + PRESC_W'(1);
        end

        // Counter step: events, interrupt and increment.
        if (step_fire)
        begin
            presc_cnt_next = '0;
            if (evten_reg[EVT_OVF] && (count_reg == CTR_MAX))
            begin
                ovf_pend_next = 1'b1;
            end
            if (evten_reg[EVT_TICK])
            begin
                event_next[EVT_TICK] = DATA_W'(1);
                if (inten_reg[EVT_TICK])
                begin
                    fire = 1'b1;
                end
            end
            if (ovf_pend_next && (count_reg == '0) && !skip_reg)
            begin
                event_next[EVT_OVF] = DATA_W'(1);
                res.notify_pulse    = 1'b1;
                ovf_pend_next       = 1'b0;
                if (inten_reg[EVT_OVF])
                begin
                    fire = 1'b1;
                end
            end
            for (int ch = 0; ch < NUM_COMPARE; ch++)
            begin
                if (evten_reg[CMP_BIT_BASE + ch] && (count_ext == cc_reg[ch]) && !skip_reg)
                begin
                    event_next[EVT_CMP0 + ch] = DATA_W'(1);
                    res.notify_pulse          = 1'b1;
                    if (inten_reg[CMP_BIT_BASE + ch])
                    begin
                        fire = 1'b1;
                    end
                end
            end
            res.irq_pulse = fire;
            if (clr_pend_reg)
            begin
                clr_pend_next = 1'b0;
                count_next    = '0;
                skip_next     = 1'b1;
            end
            else
            begin
                count_next = count_reg + COUNTER_BITS'(1);
                skip_next  = 1'b0;
            end
            task_next[TASK_CLEAR] = '0;
        end
    end

    // State registers, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            presc_cnt_reg <= '0;
            presc_set_reg <= '0;
            evten_reg     <= '0;
            inten_reg     <= '0;
            ovf_pend_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            clr_pend_reg  <= 1'b0;
            for (int i = 0; i < MAX_COMPARE; i++)
            begin
                cc_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                event_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                task_reg[i] <= '0;
            end
            task_reg[TASK_STOP] <= DATA_W'(1);
            setclr_reg[0]       <= '0;
            setclr_reg[1]       <= '0;
        end
        else if (adv)
        begin
            count_reg     <= count_next;
            presc_cnt_reg <= presc_cnt_next;
            presc_set_reg <= presc_set_next;
            cc_reg        <= cc_next;
            evten_reg     <= evten_next;
            inten_reg     <= inten_next;
            event_reg     <= event_next;
            task_reg      <= task_next;
            setclr_reg    <= setclr_next;
            ovf_pend_reg  <= ovf_pend_next;
            skip_reg      <= skip_next;
            clr_pend_reg  <= clr_pend_next;
        end
    end

`ifndef SYNTH
    // Start and stop words are never both nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !((task_reg[TASK_START] != '0) && (task_reg[TASK_STOP] != '0)))
    else $error("start and stop words both nonzero");

    // A step with a clear armed zeroes the counter and suppresses the next matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_fire && clr_pend_reg) |=> ((count_reg == '0) && skip_reg))
    else $error("clear did not take effect at step");

    // A step without a clear increments the counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_fire && !clr_pend_reg)
        |=> (count_reg == $past(count_reg) + COUNTER_BITS'(1)) && !skip_reg)
    else $error("counter did not increment on step");

    // A tick that causes no step gives neither interrupt nor notification.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((item.action == ACT_TICK) && !step_fire) |-> (!res.irq_pulse && !res.notify_pulse))
    else $error("pulse raised without a counter step");
`endif

endmodule

`default_nettype wire

### rtl/rtc_counter_compare_peripheral.sv
// Real-time counter with compare channels: top level with input and result registers.
// Depends on rtcc_pkg, rtcc_if (rtcc_cmd_if, rtcc_rsp_if) and rtcc_core.
//
// Usage:
//   cmd carries one item per transfer: a register write, a register read or
//   one tick of the low-frequency clock (action, reg_index, write_data).
//   rsp returns exactly one result per item, in order: read_data on a read,
//   irq_pulse when a counter step raised an enabled interrupt, notify_pulse
//   on an event register write or an overflow or compare event, and
//   prescaler_error when a prescaler write above 4095 was rejected.
//   The item is captured in the input register; when it advances, its result
//   is loaded into the result register and all register state is updated.
//   Throughput is one item per cycle while rsp is not stalled; the limit is
//   the update of the register state between the input and result registers.
//   A stalled rsp holds the result; the input register still takes one more
//   item, and cmd.ready drops only when both registers are full.
//   Reset clears all state: the counter is stopped (stop word one), all
//   enables, events, compare words and the prescaler are zero.
`default_nettype none

module rtc_counter_compare_peripheral import rtcc_pkg::*; #(
    parameter int NUM_COMPARE  = NUM_COMPARE_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rtcc_cmd_if.sink     cmd,
    rtcc_rsp_if.source   rsp
);

    logic    in_vld_reg;
    item_t   item_reg;
    logic    out_vld_reg;
    result_t res_reg;
    result_t res;
    logic    adv;

    // The held item moves on when the result register is free or being drained.
    assign adv       = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign cmd.ready = !in_vld_reg || adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.action     <= cmd.action;
            item_reg.reg_index  <= cmd.reg_index;
            item_reg.write_data <= cmd.write_data;
        end
    end

    rtcc_core #(
        .NUM_COMPARE  (NUM_COMPARE),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item_reg),
        .res   (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.read_data       = res_reg.read_data;
    assign rsp.irq_pulse       = res_reg.irq_pulse;
    assign rsp.notify_pulse    = res_reg.notify_pulse;
    assign rsp.prescaler_error = res_reg.prescaler_error;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the real-time counter with compare channels.
// Drives register writes, reads and clock ticks over rtcc_cmd_if and checks every
// response against an in-bench model; needs rtcc_pkg, rtcc_if and the top level.

module tb_top;

    import rtcc_pkg::*;

    // Action code the block ignores, the highest register index and the lowest unused one.
    localparam logic [ACTION_W-1:0] ACT_NONE       = 2'd3;
    localparam logic [INDEX_W-1:0]  REG_UNUSED_TOP = 5'd31;
    localparam logic [INDEX_W-1:0]  REG_UNUSED_LOW = 5'd21;

    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [COUNTER_BITS_DEF-1:0] COUNT_TOP = '1;

    logic clk;
    logic rst_n;

    rtcc_cmd_if cmd_ch ();
    rtcc_rsp_if rsp_ch ();

    rtc_counter_compare_peripheral u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Commands waiting to be offered, and responses predicted but not yet seen.
    item_t   pending_commands [$];
    result_t pending_responses [$];
    item_t   in_flight;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int responses_seen;
    int hold_left;
    int quiet_cycles;
    int commands_made;

    // Model state of the peripheral, starting from its reset values.
    logic [COUNTER_BITS_DEF-1:0] count_q      = '0;
    logic [PRESC_W-1:0]          presc_cnt    = '0;
    logic [PRESC_W-1:0]          presc_set    = '0;
    logic [DATA_W-1:0]           cmp_word [MAX_COMPARE] = '{default: '0};
    logic [DATA_W-1:0]           ev_en        = '0;
    logic [DATA_W-1:0]           int_en       = '0;
    logic [DATA_W-1:0]           ev_word [NUM_EVENTS]   = '{default: '0};
    logic [DATA_W-1:0]           task_word [NUM_TASKS]  = '{32'd0, 32'd1, 32'd0, 32'd0};
    logic [DATA_W-1:0]           setclr_word [2]        = '{default: '0};
    logic                        ovf_armed     = 1'b0;
    logic                        match_blocked = 1'b0;
    logic                        clear_armed   = 1'b0;

    // Applies one accepted command to the model and returns its response.
    function automatic result_t next_response(item_t cmd);
        result_t rsp;
        logic    fire;
        logic [DATA_W-1:0]  d;
        logic [INDEX_W-1:0] idx;
        d   = cmd.write_data;
        idx = cmd.reg_index;
        rsp = '0;
        fire = 1'b0;
        if (cmd.action == ACT_WRITE) begin
            if (idx == REG_START) begin
                task_word[TASK_START] = d;
                if (d != 0) task_word[TASK_STOP] = '0;
            end else if (idx == REG_STOP) begin
                task_word[TASK_STOP] = d;
                if (d != 0) task_word[TASK_START] = '0;
            end else if (idx == REG_CLEAR) begin
                task_word[TASK_CLEAR] = d;
                clear_armed = 1'b1;
            end else if (idx == REG_TRIGOVF) begin
                task_word[TASK_TRIG] = d;
                count_q = COUNT_TOP - COUNTER_BITS_DEF'(TRIGOVF_BACKOFF);
            end else if (idx <= REG_EVCMP3) begin
                ev_word[idx - REG_EVTICK] = d;
                rsp.notify_pulse = 1'b1;
            end else if (idx == REG_EVTEN) begin
                ev_en = d;
            end else if (idx == REG_EVTENSET) begin
                setclr_word[0] = d;
                ev_en = ev_en | d;
            end else if (idx == REG_EVTENCLR) begin
                setclr_word[1] = d;
                ev_en = ev_en & ~d;
            end else if (idx == REG_INTENSET) begin
                int_en = int_en | d;
            end else if (idx == REG_INTENCLR) begin
                int_en = int_en & ~d;
            end else if (idx == REG_PRESCALER) begin
                if (d > PRESCALE_MAX) rsp.prescaler_error = 1'b1;
                else presc_set = d[PRESC_W-1:0];
            end else if (idx >= REG_CC0 && idx <= REG_CC3) begin
                cmp_word[idx - REG_CC0] = d;
            end
        end else if (cmd.action == ACT_READ) begin
            if (idx <= REG_TRIGOVF)        rsp.read_data = task_word[idx];
            else if (idx <= REG_EVCMP3)    rsp.read_data = ev_word[idx - REG_EVTICK];
            else if (idx == REG_EVTEN)     rsp.read_data = ev_en;
            else if (idx <= REG_EVTENCLR)  rsp.read_data = setclr_word[idx - REG_EVTENSET];
            else if (idx <= REG_INTENCLR)  rsp.read_data = int_en;
            else if (idx == REG_COUNTER)   rsp.read_data = DATA_W'(count_q);
            else if (idx == REG_PRESCALER) rsp.read_data = DATA_W'(presc_set);
            else if (idx <= REG_CC3)       rsp.read_data = cmp_word[idx - REG_CC0];
        end else if (cmd.action == ACT_TICK) begin
            // Ticks only count while running; a step happens once the prescaler wraps.
            if (task_word[TASK_STOP] == 0 || task_word[TASK_START] != 0) begin
                if (presc_cnt >= presc_set) begin
                    presc_cnt = '0;
                    if (ev_en[EVT_OVF] && count_q == COUNT_TOP) ovf_armed = 1'b1;
                    if (ev_en[EVT_TICK]) begin
                        ev_word[EVT_TICK] = 32'd1;
                        if (int_en[EVT_TICK]) fire = 1'b1;
                    end
                    if (ovf_armed && count_q == 0 && !match_blocked) begin
                        ev_word[EVT_OVF] = 32'd1;
                        rsp.notify_pulse = 1'b1;
                        if (int_en[EVT_OVF]) fire = 1'b1;
                        ovf_armed = 1'b0;
                    end
                    for (int ch = 0; ch < NUM_COMPARE_DEF; ch++) begin
                        if (ev_en[CMP_BIT_BASE + ch] && !match_blocked &&
                            cmp_word[ch] == DATA_W'(count_q)) begin
                            ev_word[EVT_CMP0 + ch] = 32'd1;
                            rsp.notify_pulse = 1'b1;
                            if (int_en[CMP_BIT_BASE + ch]) fire = 1'b1;
                        end
                    end
                    rsp.irq_pulse = fire;
                    count_q = count_q + 1'b1;
                    // A pending clear lands here and masks matches on the following step.
                    match_blocked = clear_armed;
                    if (clear_armed) count_q = '0;
                    clear_armed = 1'b0;
                    task_word[TASK_CLEAR] = '0;
                end else begin
                    presc_cnt = presc_cnt + 1'b1;
                end
            end
        end
        return rsp;
    endfunction

    task automatic add_command(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                               logic [DATA_W-1:0] data);
        item_t cmd;
        cmd.action     = act;
        cmd.reg_index  = idx;
        cmd.write_data = data;
        pending_commands.push_back(cmd);
        if (act != ACT_NONE && !(act == ACT_WRITE && idx >= REG_UNUSED_LOW))
            commands_made++;
    endtask

    // Compare values biased toward counts the counter actually reaches.
    function automatic logic [DATA_W-1:0] compare_value();
        case ($urandom_range(0, 3))
            0:       return DATA_W'($urandom_range(0, 24));
            1:       return 32'h00FF_FFF0 + $urandom_range(0, 15);
            2:       return $urandom | 32'h0100_0000;
            default: return $urandom & 32'h00FF_FFFF;
        endcase
    endfunction

    // One setup sequence followed by a body of mostly ticks with reads and noise mixed in.
    task automatic random_episode();
        int pick;
        int body_len;
        logic [DATA_W-1:0] d;
        if ($urandom_range(0, 3) != 0) add_command(ACT_WRITE, REG_START, $urandom | 32'd1);
        if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 10)      d = '0;
            else if (pick < 16) d = $urandom_range(1, 3);
            else if (pick < 18) d = $urandom;
            else                d = PRESCALE_MAX + $urandom_range(0, 1);
            add_command(ACT_WRITE, REG_PRESCALER, d);
        end
        if ($urandom_range(0, 1) == 0) begin
            d = $urandom;
            if ($urandom_range(0, 1) == 0) d = d | 32'h000F_0003;
            add_command(ACT_WRITE, ($urandom_range(0, 1) == 0) ? REG_EVTEN : REG_EVTENSET, d);
        end
        if ($urandom_range(0, 1) == 0) add_command(ACT_WRITE, REG_INTENSET, $urandom);
        if ($urandom_range(0, 3) == 0) add_command(ACT_WRITE, REG_INTENCLR, $urandom);
        if ($urandom_range(0, 5) == 0) add_command(ACT_WRITE, REG_EVTENCLR, $urandom);
        for (int ch = 0; ch < NUM_COMPARE_DEF; ch++) begin
            if ($urandom_range(0, 1) == 0)
                add_command(ACT_WRITE, INDEX_W'(REG_CC0 + ch), compare_value());
        end
        pick = $urandom_range(0, 5);
        if (pick < 2)       add_command(ACT_WRITE, REG_TRIGOVF, $urandom);
        else if (pick == 2) add_command(ACT_WRITE, REG_CLEAR, $urandom);

        body_len = $urandom_range(10, 80);
        repeat (body_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                add_command(ACT_TICK, INDEX_W'($urandom_range(0, 31)), $urandom);
            else if (pick < 83)
                add_command(ACT_READ, INDEX_W'($urandom_range(0, 31)), $urandom);
            else if (pick < 86)
                add_command(ACT_NONE, INDEX_W'($urandom_range(0, 31)), $urandom);
            else if (pick < 89)
                add_command(ACT_WRITE, REG_STOP, ($urandom_range(0, 1) == 0) ? '0 : $urandom);
            else if (pick < 91)
                add_command(ACT_WRITE, REG_START, $urandom);
            else if (pick < 93)
                add_command(ACT_WRITE, REG_CLEAR, $urandom);
            else if (pick < 94)
                add_command(ACT_WRITE, REG_TRIGOVF, $urandom);
            else
                add_command(ACT_WRITE, INDEX_W'($urandom_range(0, 31)), $urandom);
        end
    endtask

    task automatic fill_random(int target);
        int start;
        start = commands_made;
        while (commands_made - start < target) random_episode();
    endtask

    // Holds the sender until every queued command has been answered.
    // Sampled on the falling edge, once the driver and monitor have settled.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_commands.size() != 0 || cmd_ch.valid || pending_responses.size() != 0);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Command driver: predicts each accepted transfer and offers the next one.
    always @(posedge clk or negedge rst_n) begin : cmd_driver
        item_t nxt;
        if (!rst_n) begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.action     <= '0;
            cmd_ch.reg_index  <= '0;
            cmd_ch.write_data <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                pending_responses.push_back(next_response(in_flight));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_commands.pop_front();
                    in_flight = nxt;
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.action     <= nxt.action;
                    cmd_ch.reg_index  <= nxt.reg_index;
                    cmd_ch.write_data <= nxt.write_data;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each transfer and drives ready, with occasional long holds.
    always @(posedge clk or negedge rst_n) begin : rsp_monitor
        result_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_responses.size() == 0) begin
                    $error("response transfer with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_responses.pop_front();
                    check_field("read_data", want.read_data, rsp_ch.read_data);
                    check_field("irq_pulse", DATA_W'(want.irq_pulse), DATA_W'(rsp_ch.irq_pulse));
                    check_field("notify_pulse", DATA_W'(want.notify_pulse),
                                DATA_W'(rsp_ch.notify_pulse));
                    check_field("prescaler_error", DATA_W'(want.prescaler_error),
                                DATA_W'(rsp_ch.prescaler_error));
                end
                responses_seen++;
                if (responses_seen == 200 || responses_seen == 1300) hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequencing and final verdict.
    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = '0;
        cmd_ch.reg_index  = '0;
        cmd_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        mismatch_count    = 0;
        responses_seen    = 0;
        quiet_cycles      = 0;
        commands_made     = 0;
        send_idle_pct     = 25;
        recv_idle_pct     = 86;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, prescaler limits, ticks while stopped.
        add_command(ACT_READ, REG_STOP, '0);
        add_command(ACT_WRITE, REG_PRESCALER, PRESCALE_MAX + 1);
        add_command(ACT_WRITE, REG_PRESCALER, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_PRESCALER, PRESCALE_MAX);
        add_command(ACT_READ, REG_PRESCALER, 32'hFFFF_FFFF);
        add_command(ACT_TICK, REG_UNUSED_TOP, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_PRESCALER, '0);
        // Compare match just after a forced overflow preload, then a clear.
        add_command(ACT_WRITE, REG_EVTEN, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_INTENSET, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_CC0, 32'h00FF_FFF1);
        add_command(ACT_WRITE, REG_CC3, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_START, 32'd1);
        add_command(ACT_WRITE, REG_TRIGOVF, '0);
        add_command(ACT_TICK, '0, '0);
        add_command(ACT_TICK, '0, '0);
        add_command(ACT_WRITE, REG_CLEAR, '0);
        add_command(ACT_TICK, '0, '0);
        add_command(ACT_TICK, '0, '0);
        add_command(ACT_READ, REG_COUNTER, '0);
        // Ignored writes, unused index and action, stop and event writes.
        add_command(ACT_WRITE, REG_COUNTER, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_UNUSED_TOP, 32'hA5A5_5A5A);
        add_command(ACT_READ, REG_UNUSED_LOW, '0);
        add_command(ACT_NONE, REG_UNUSED_TOP, 32'hFFFF_FFFF);
        add_command(ACT_WRITE, REG_STOP, 32'd5);
        add_command(ACT_WRITE, REG_EVTICK + 5'd2, 32'hFFFF_FFFF);
        add_command(ACT_READ, REG_EVTICK + 5'd2, '0);
        add_command(ACT_WRITE, REG_EVTENCLR, 32'hFFFF_0000);
        add_command(ACT_WRITE, REG_INTENCLR, 32'hFFFF_FFFF);

        fill_random(575);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 25;
        fill_random(575);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(575);
        wait_drained();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/rtcc_pkg.sv
rtl/rtcc_if.sv
rtl/rtcc_core.sv
rtl/rtc_counter_compare_peripheral.sv
tb/tb_top.sv
